/* rtl/core/gcdist_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcdist_pkg
// Shared types and fixed constants of the great-circle distance pipeline.
// ----------------------------------------------------------------------------
package gcdist_pkg;

  // Taylor series length and pipeline depth of one sine/cosine unit
  localparam int TRIG_TERMS = 10;
  localparam int TRIG_LAT   = 2 * TRIG_TERMS + 2;

  // pi with 62 fraction bits, and one millidegree in radians at the same scale
  localparam logic [63:0] PI_Q62     = 64'hC90FDAA22168C235;
  localparam logic [63:0] MD_RAD_Q62 = PI_Q62 / 64'd180000;

  // miles, kilometers and nautical miles per radian, Q16
  localparam logic [63:0] MILES_Q16 =
    (64'd180 * 64'd69090 * 64'd10000000 * 64'd65536) / 64'd31415926535;
  localparam logic [63:0] KM_Q16 = (MILES_Q16 * 64'd1609344) / 64'd1000000;
  localparam logic [63:0] NM_Q16 = (MILES_Q16 * 64'd8684) / 64'd10000;
  localparam int          SCALE_W = 29;

  // angle landmarks in millidegrees
  localparam int QUARTER_TURN_MD = 90000;
  localparam int HALF_TURN_MD    = 180000;
  localparam int FULL_TURN_MD    = 360000;

  // unit register codes
  typedef enum logic [1:0] {
    UNIT_MILES = 2'd0,
    UNIT_KM    = 2'd1,
    UNIT_NM    = 2'd2
  } unit_t;

  // control that rides along with every item
  typedef struct packed {
    logic valid;
    logic same;
  } side_t;

endpackage
`default_nettype wire

/* rtl/core/gcdist_trig.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcdist_trig
// Pipelined sine or cosine of an angle in [0, pi/2] by a Horner Taylor series,
// two stages per term, result clamped to [0, 1].
// ----------------------------------------------------------------------------
module gcdist_trig
  import gcdist_pkg::*;
#(
  parameter int FRAC = 30,
  parameter bit SIN  = 1'b0
) (
  input  logic            clk,
  input  logic            en,
  input  logic [FRAC:0]   x,
  output logic [FRAC:0]   y
);

  localparam int TW = FRAC + 2;       // signed Horner value
  localparam int PW = FRAC + 2;       // product magnitude
  localparam int MW = 2 * FRAC + 3;
  localparam int FW = 2 * FRAC + 2;
  localparam logic signed [TW-1:0] ONE  = {2'b01, {FRAC{1'b0}}};
  localparam logic        [TW-1:0] ONEU = {2'b01, {FRAC{1'b0}}};

  logic [FRAC:0]        x_l  [0:2*TRIG_TERMS];
  logic [PW-1:0]        x2_l [0:2*TRIG_TERMS-1];
  logic signed [TW-1:0] t_l  [1:TRIG_TERMS];
  logic [PW-1:0]        p_l  [0:TRIG_TERMS-1];
  logic                 n_l  [0:TRIG_TERMS-1];
  logic [MW-1:0]        sq;

  // x squared
  assign sq = MW'(x) * MW'(x);

  always_ff @(posedge clk) begin
    if (en) begin
      x_l[0]  <= x;
      x2_l[0] <= sq[FRAC +: PW];
    end
  end

  // x follows along for the final sine product
  for (genvar j = 1; j <= 2 * TRIG_TERMS; j++) begin : g_xline
    always_ff @(posedge clk) begin
      if (en) x_l[j] <= x_l[j-1];
    end
  end

  // one Horner term: t = 1 - x2 * t / d
  for (genvar i = 0; i < TRIG_TERMS; i++) begin : g_term
    localparam int K = TRIG_TERMS - i;
    localparam int D = SIN ? (2 * K) * (2 * K + 1) : (2 * K - 1) * (2 * K);
    localparam int L = $clog2(D);
    localparam int S = PW + L;
    // exact reciprocal for dividends below 2^PW
    localparam logic [63:0] RECIP = ((64'd1 << S) + 64'(D) - 64'd1) / 64'(D);

    logic signed [TW-1:0] tin;
    logic signed [TW-1:0] tneg;
    logic [FRAC:0]        tmag;
    logic [MW-1:0]        pm;
    logic [2*PW:0]        qm;
    logic signed [TW-1:0] q;

    if (i == 0) begin : g_first
      assign tin = ONE;
    end else begin : g_next
      assign tin = t_l[i];
    end

    always_comb begin
      tneg = -tin;
      tmag = tin[TW-1] ? tneg[FRAC:0] : tin[FRAC:0];
      pm   = MW'(x2_l[2*i]) * MW'(tmag);
      qm   = (2*PW+1)'(p_l[i]) * (2*PW+1)'(RECIP[PW:0]);
      q    = signed'(TW'(qm[2*PW:S]));
    end

    // stage A: magnitude product, truncated
    always_ff @(posedge clk) begin
      if (en) begin
        p_l[i]      <= pm[FRAC +: PW];
        n_l[i]      <= tin[TW-1];
        x2_l[2*i+1] <= x2_l[2*i];
      end
    end

    // stage B: divide by the term constant, subtract from one
    always_ff @(posedge clk) begin
      if (en) t_l[i+1] <= n_l[i] ? ONE + q : ONE - q;
    end

    if (i < TRIG_TERMS - 1) begin : g_x2
      always_ff @(posedge clk) begin
        if (en) x2_l[2*i+2] <= x2_l[2*i+1];
      end
    end
  end

  // final stage: sine takes x * t, then clamp to [0, 1]
  logic signed [TW-1:0] tf;
  logic signed [TW-1:0] tfn;
  logic [FRAC:0]        tfm;
  logic [FW-1:0]        sm;
  logic [FRAC+1:0]      v;

  always_comb begin
    tf  = t_l[TRIG_TERMS];
    tfn = -tf;
    tfm = tf[TW-1] ? tfn[FRAC:0] : tf[FRAC:0];
    sm  = FW'(x_l[2*TRIG_TERMS]) * FW'(tfm);
    v   = SIN ? sm[FRAC +: FRAC+2] : {1'b0, tfm};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (tf[TW-1]) y <= '0;
      else if (v > ONEU) y <= ONEU[FRAC:0];
      else y <= v[FRAC:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/gcdist_acos.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcdist_acos
// Pipelined arc cosine: bit-by-bit search for the largest angle whose cosine
// is at least c, one cosine unit per result bit.
// ----------------------------------------------------------------------------
module gcdist_acos
  import gcdist_pkg::*;
#(
  parameter int FRAC = 30
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  side_t                  side_in,
  input  logic signed [FRAC+1:0] c_in,
  output side_t                  side_out,
  output logic [FRAC+1:0]        ang
);

  localparam int AW    = FRAC + 2;
  localparam int ITERS = FRAC + 2;
  localparam logic [63:0] PI_W =
    (PI_Q62 + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
  localparam logic [AW-1:0]        PI_QF   = PI_W[AW-1:0];
  localparam logic [AW-1:0]        HALF_PI = PI_QF >> 1;
  localparam logic signed [AW-1:0] ONE     = {2'b01, {FRAC{1'b0}}};
  localparam logic signed [AW-1:0] NEG_ONE = -ONE;

  logic [AW-1:0]        lo_b   [1:ITERS];
  logic signed [AW-1:0] c_b    [1:ITERS];
  side_t                side_b [1:ITERS];

  for (genvar j = 0; j < ITERS; j++) begin : g_bit
    localparam int B = ITERS - 1 - j;
    localparam logic [AW-1:0] BIT = {{(AW-1){1'b0}}, 1'b1} << B;

    logic [AW-1:0]        lo_i;
    logic signed [AW-1:0] c_i;
    side_t                side_i;
    logic [AW-1:0]        cand;
    logic [AW-1:0]        diff;

    if (j == 0) begin : g_first
      assign lo_i   = '0;
      assign c_i    = c_in;
      assign side_i = side_in;
    end else begin : g_next
      assign lo_i   = lo_b[j];
      assign c_i    = c_b[j];
      assign side_i = side_b[j];
    end

    // candidate angle, folded into [0, pi/2]
    assign cand = lo_i | BIT;
    assign diff = PI_QF - cand;

    logic [AW-1:0]        p_lo;
    logic signed [AW-1:0] p_c;
    side_t                p_side;
    logic                 p_ok;
    logic                 p_big;
    logic [FRAC:0]        p_x;

    always_ff @(posedge clk) begin
      if (rst) begin
        p_side <= '0;
      end else if (en) begin
        p_side <= side_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_lo  <= lo_i;
        p_c   <= c_i;
        p_ok  <= cand <= PI_QF;
        p_big <= cand > HALF_PI;
        p_x   <= (cand > HALF_PI) ? diff[FRAC:0] : cand[FRAC:0];
      end
    end

    logic [FRAC:0] ty;

    gcdist_trig #(
      .FRAC (FRAC),
      .SIN  (1'b0)
    ) u_cos (
      .clk (clk),
      .en  (en),
      .x   (p_x),
      .y   (ty)
    );

    // item data waits for the cosine
    logic [AW-1:0]        d_lo   [0:TRIG_LAT-1];
    logic signed [AW-1:0] d_c    [0:TRIG_LAT-1];
    logic                 d_ok   [0:TRIG_LAT-1];
    logic                 d_big  [0:TRIG_LAT-1];
    side_t                d_side [0:TRIG_LAT-1];

    always_ff @(posedge clk) begin
      if (en) begin
        d_lo[0]  <= p_lo;
        d_c[0]   <= p_c;
        d_ok[0]  <= p_ok;
        d_big[0] <= p_big;
        for (int k = 1; k < TRIG_LAT; k++) begin
          d_lo[k]  <= d_lo[k-1];
          d_c[k]   <= d_c[k-1];
          d_ok[k]  <= d_ok[k-1];
          d_big[k] <= d_big[k-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        for (int k = 0; k < TRIG_LAT; k++) d_side[k] <= '0;
      end else if (en) begin
        d_side[0] <= p_side;
        for (int k = 1; k < TRIG_LAT; k++) d_side[k] <= d_side[k-1];
      end
    end

    // keep the bit when cos(candidate) >= c
    logic signed [AW-1:0] cpos;
    logic signed [AW-1:0] cosv;
    logic                 take;

    always_comb begin
      cpos = signed'({1'b0, ty});
      cosv = d_big[TRIG_LAT-1] ? -cpos : cpos;
      take = d_ok[TRIG_LAT-1] && (cosv >= d_c[TRIG_LAT-1]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lo_b[j+1] <= take ? (d_lo[TRIG_LAT-1] | BIT) : d_lo[TRIG_LAT-1];
        c_b[j+1]  <= d_c[TRIG_LAT-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side_b[j+1] <= '0;
      end else if (en) begin
        side_b[j+1] <= d_side[TRIG_LAT-1];
      end
    end
  end

  // c at the ends of the range gives 0 or pi directly
  assign side_out = side_b[ITERS];

  always_comb begin
    if (c_b[ITERS] >= ONE) ang = '0;
    else if (c_b[ITERS] <= NEG_ONE) ang = PI_QF;
    else ang = lo_b[ITERS];
  end

endmodule
`default_nettype wire

/* rtl/core/great_circle_distance.sv */
// Throughput: one item per cycle unless the output stalls; the arc cosine is F + 2
//   chained cosine units, each a 22-stage Horner pipeline, and every stage holds one item.
// A stall at the output freezes the whole pipeline; bubbles travel with it.
// Reset (rst, synchronous) empties the pipeline and sets the unit to kilometers.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// great_circle_distance
// Spherical law of cosines distance between two points given in millidegrees,
// in statute miles, kilometers or nautical miles.
// ----------------------------------------------------------------------------
module great_circle_distance
  import gcdist_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  input  logic               point_valid,
  output logic               point_ready,
  input  logic signed [17:0] lat_a,
  input  logic signed [18:0] lon_a,
  input  logic signed [17:0] lat_b,
  input  logic signed [18:0] lon_b,
  output logic               dist_valid,
  input  logic               dist_ready,
  output logic [14:0]        distance
);

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int SH = 62 - F;
  localparam int CW = F + 2;            // signed cosine of the central angle
  localparam int SW = F + 3;            // signed sum before clamping
  localparam int PW = 2 * F + 2;
  localparam int DW = CW + SCALE_W;
  localparam logic signed [CW-1:0] ONE     = {2'b01, {F{1'b0}}};
  localparam logic signed [SW-1:0] ONE_S   = {3'b001, {F{1'b0}}};
  localparam logic signed [SW-1:0] NEG_ONE = -ONE_S;
  localparam logic [63:0]          PI_W    = (PI_Q62 + (64'd1 << (61 - F))) >> SH;
  localparam logic [CW-1:0]        PI_QF   = PI_W[CW-1:0];
  localparam logic [14:0]          DIST_MAX = 15'd20100;

  typedef struct packed {
    logic [16:0] mag;
    logic        sneg;
    logic        cneg;
  } fold_t;

  typedef struct packed {
    logic sna;
    logic snb;
    logic cna;
    logic cnb;
    logic cnd;
  } sgn_t;

  // fold an angle in (-180, 180] degrees onto [0, 90] with the signs of sin, cos
  function automatic fold_t fold_md(input logic signed [18:0] r);
    fold_t       f;
    logic [18:0] a;
    a      = r[18] ? unsigned'(-r) : unsigned'(r);
    f.sneg = r[18];
    f.cneg = a > 19'(QUARTER_TURN_MD);
    f.mag  = f.cneg ? 17'(19'(HALF_TURN_MD) - a) : a[16:0];
    return f;
  endfunction

  // millidegrees to radians, rounded
  function automatic logic [F:0] md_to_rad(input logic [16:0] a);
    logic [63:0] p;
    p = 64'(a) * MD_RAD_Q62 + (64'd1 << (SH - 1));
    return p[SH +: F+1];
  endfunction

  logic en;
  logic [1:0] distance_unit;

  assign en          = !dist_valid || dist_ready;
  assign point_ready = en && !rst;

  // unit register
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_unit <= UNIT_KM;
    end else if (cfg_we) begin
      distance_unit <= cfg_wdata;
    end
  end

  // ---- f1: longitude difference, wrapped into (-180, 180] degrees
  logic signed [19:0] dl;
  logic signed [19:0] dw;
  side_t              f1_side;
  logic signed [17:0] f1_lat_a;
  logic signed [17:0] f1_lat_b;
  logic signed [18:0] f1_dlon;

  always_comb begin
    dl = 20'(lon_a) - 20'(lon_b);
    if (dl > 20'sd180000) dw = dl - 20'sd360000;
    else if (dl <= -20'sd180000) dw = dl + 20'(FULL_TURN_MD);
    else dw = dl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_side <= '0;
    end else if (en) begin
      f1_side.valid <= point_valid;
      f1_side.same  <= (lat_a == lat_b) && (lon_a == lon_b);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_lat_a <= lat_a;
      f1_lat_b <= lat_b;
      f1_dlon  <= dw[18:0];
    end
  end

  // ---- f2: fold into the first quadrant
  side_t f2_side;
  fold_t f2_a;
  fold_t f2_b;
  fold_t f2_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_side <= '0;
    end else if (en) begin
      f2_side <= f1_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_a <= fold_md(19'(f1_lat_a));
      f2_b <= fold_md(19'(f1_lat_b));
      f2_d <= fold_md(f1_dlon);
    end
  end

  // ---- f3: radians
  side_t      f3_side;
  sgn_t       f3_sgn;
  logic [F:0] f3_xa;
  logic [F:0] f3_xb;
  logic [F:0] f3_xd;

  always_ff @(posedge clk) begin
    if (rst) begin
      f3_side <= '0;
    end else if (en) begin
      f3_side <= f2_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3_xa      <= md_to_rad(f2_a.mag);
      f3_xb      <= md_to_rad(f2_b.mag);
      f3_xd      <= md_to_rad(f2_d.mag);
      f3_sgn.sna <= f2_a.sneg;
      f3_sgn.snb <= f2_b.sneg;
      f3_sgn.cna <= f2_a.cneg;
      f3_sgn.cnb <= f2_b.cneg;
      f3_sgn.cnd <= f2_d.cneg;
    end
  end

  // ---- five sine/cosine units in parallel
  logic [F:0] sa;
  logic [F:0] sb;
  logic [F:0] ca;
  logic [F:0] cb;
  logic [F:0] cd;

  gcdist_trig #(.FRAC(F), .SIN(1'b1)) u_sin_a (.clk(clk), .en(en), .x(f3_xa), .y(sa));
  gcdist_trig #(.FRAC(F), .SIN(1'b1)) u_sin_b (.clk(clk), .en(en), .x(f3_xb), .y(sb));
  gcdist_trig #(.FRAC(F), .SIN(1'b0)) u_cos_a (.clk(clk), .en(en), .x(f3_xa), .y(ca));
  gcdist_trig #(.FRAC(F), .SIN(1'b0)) u_cos_b (.clk(clk), .en(en), .x(f3_xb), .y(cb));
  gcdist_trig #(.FRAC(F), .SIN(1'b0)) u_cos_d (.clk(clk), .en(en), .x(f3_xd), .y(cd));

  side_t t_side [0:TRIG_LAT-1];
  sgn_t  t_sgn  [0:TRIG_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TRIG_LAT; k++) t_side[k] <= '0;
    end else if (en) begin
      t_side[0] <= f3_side;
      for (int k = 1; k < TRIG_LAT; k++) t_side[k] <= t_side[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_sgn[0] <= f3_sgn;
      for (int k = 1; k < TRIG_LAT; k++) t_sgn[k] <= t_sgn[k-1];
    end
  end

  // ---- m1: sin*sin and cos*cos, sign and magnitude
  logic [PW-1:0] ss_p;
  logic [PW-1:0] cc_p;
  side_t         m1_side;
  logic [F:0]    m1_ss;
  logic [F:0]    m1_cc;
  logic [F:0]    m1_cd;
  logic          m1_ssn;
  logic          m1_ccn;
  logic          m1_cdn;

  assign ss_p = PW'(sa) * PW'(sb);
  assign cc_p = PW'(ca) * PW'(cb);

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_side <= '0;
    end else if (en) begin
      m1_side <= t_side[TRIG_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_ss  <= ss_p[F +: F+1];
      m1_cc  <= cc_p[F +: F+1];
      m1_cd  <= cd;
      m1_ssn <= t_sgn[TRIG_LAT-1].sna ^ t_sgn[TRIG_LAT-1].snb;
      m1_ccn <= t_sgn[TRIG_LAT-1].cna ^ t_sgn[TRIG_LAT-1].cnb;
      m1_cdn <= t_sgn[TRIG_LAT-1].cnd;
    end
  end

  // ---- m2: times cos of the longitude difference
  logic [PW-1:0] ccc_p;
  side_t         m2_side;
  logic [F:0]    m2_ss;
  logic [F:0]    m2_ccc;
  logic          m2_ssn;
  logic          m2_cccn;

  assign ccc_p = PW'(m1_cc) * PW'(m1_cd);

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_side <= '0;
    end else if (en) begin
      m2_side <= m1_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_ss   <= m1_ss;
      m2_ssn  <= m1_ssn;
      m2_ccc  <= ccc_p[F +: F+1];
      m2_cccn <= m1_ccn ^ m1_cdn;
    end
  end

  // ---- m3: sum and clamp to [-1, 1]
  logic signed [SW-1:0] sv;
  logic signed [SW-1:0] cv;
  logic signed [SW-1:0] csum;
  side_t                m3_side;
  logic signed [CW-1:0] m3_c;

  always_comb begin
    sv   = signed'(SW'(m2_ss));
    cv   = signed'(SW'(m2_ccc));
    csum = (m2_ssn ? -sv : sv) + (m2_cccn ? -cv : cv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_side <= '0;
    end else if (en) begin
      m3_side <= m2_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (csum > ONE_S) m3_c <= ONE;
      else if (csum < NEG_ONE) m3_c <= -ONE;
      else m3_c <= csum[CW-1:0];
    end
  end

  // ---- arc cosine
  side_t         a_side;
  logic [CW-1:0] ang;

  gcdist_acos #(
    .FRAC (F)
  ) u_acos (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .side_in  (m3_side),
    .c_in     (m3_c),
    .side_out (a_side),
    .ang      (ang)
  );

  // ---- output: scale to the selected unit
  logic [SCALE_W-1:0] scale;
  logic [DW-1:0]      dprod;
  side_t              o_side;

  always_comb begin
    case (distance_unit)
      UNIT_MILES: scale = MILES_Q16[SCALE_W-1:0];
      UNIT_NM:    scale = NM_Q16[SCALE_W-1:0];
      default:    scale = KM_Q16[SCALE_W-1:0];
    endcase
    dprod = DW'(ang) * DW'(scale);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_side <= '0;
    end else if (en) begin
      o_side <= a_side;
    end
  end

  // product top bits never exceed 15 bits, so no saturation is needed
  always_ff @(posedge clk) begin
    if (en) distance <= a_side.same ? '0 : dprod[F+16 +: 15];
  end

  assign dist_valid = o_side.valid;

  // ---- checks
  a_reset_empty : assert property (@(posedge clk) $past(rst) |-> !dist_valid)
    else $error("result valid right after reset");

  a_dist_range : assert property (@(posedge clk) disable iff (rst)
    dist_valid |-> distance <= DIST_MAX)
    else $error("distance beyond half the circumference");

  a_ang_range : assert property (@(posedge clk) disable iff (rst)
    a_side.valid |-> ang <= PI_QF)
    else $error("central angle beyond pi");

  a_same_zero : assert property (@(posedge clk) disable iff (rst)
    (en && a_side.valid && a_side.same) |=> (dist_valid && distance == '0))
    else $error("identical points gave a nonzero distance");

endmodule
`default_nettype wire

/* verif/great_circle_distance_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance_tb
// Drives point pairs through the distance pipeline with random gaps and
// output stalls, including one long output hold-off that backs the pipeline
// up to its input. Every distance is predicted in fixed point and compared
// in order. The unit register is stepped through all four codes.
// ----------------------------------------------------------------------------
module great_circle_distance_tb;
  import gcdist_pkg::*;

  localparam int          FRAC       = 30;
  localparam longint      ONE_Q      = longint'(1) << FRAC;
  localparam bit [63:0]   PI_QF      = (PI_Q62 + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
  localparam logic [1:0]  UNIT_SPARE = 2'd3;     // unused code, behaves as km
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_CYCLES = 900;    // margin beyond the pipeline latency
  localparam int          LONG_HOLD = 3000;
  localparam int          PHASE_ITEMS = 280;

  // --------------------------------------------------------------------------
  // Distance predictor and in-order expectation store
  // --------------------------------------------------------------------------
  class distance_checker;
    logic [1:0] unit;
    bit [14:0]  expected_dist[$];
    int         errors;

    function new();
      unit = UNIT_KM;
      errors = 0;
    endfunction

    // signed product, magnitude truncated
    function longint smul(longint a, longint b);
      bit         neg;
      bit [63:0]  ua, ub;
      bit [127:0] p;
      longint     r;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      p = 128'(ua) * 128'(ub);
      r = longint'(p[FRAC +: 64]);
      return neg ? -r : r;
    endfunction

    // Horner Taylor series on [0, pi/2], clamped to [0, 1]
    function longint series(bit [63:0] x, bit want_sin);
      longint xs, x2, t, r, d;
      int     k;
      xs = longint'(x);
      x2 = smul(xs, xs);
      t = ONE_Q;
      for (k = TRIG_TERMS; k >= 1; k--) begin
        d = want_sin ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
        t = ONE_Q - smul(x2, t) / d;
      end
      r = want_sin ? smul(xs, t) : t;
      if (r < 0) r = 0;
      if (r > ONE_Q) r = ONE_Q;
      return r;
    endfunction

    function bit [63:0] md_rad(longint md);
      return (64'(md) * MD_RAD_Q62 + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
    endfunction

    // fold into (-180, 180] degrees
    function longint wrap(longint md);
      longint r;
      r = md % FULL_TURN_MD;
      if (r < 0) r += FULL_TURN_MD;
      if (r > HALF_TURN_MD) r -= FULL_TURN_MD;
      return r;
    endfunction

    function longint sin_of(longint md);
      longint r, a, v;
      r = wrap(md);
      a = (r < 0) ? -r : r;
      if (a > QUARTER_TURN_MD) a = HALF_TURN_MD - a;
      v = series(md_rad(a), 1'b1);
      return (r < 0) ? -v : v;
    endfunction

    function longint cos_of(longint md);
      longint r, a, v;
      bit     neg;
      r = wrap(md);
      a = (r < 0) ? -r : r;
      neg = a > QUARTER_TURN_MD;
      if (neg) a = HALF_TURN_MD - a;
      v = series(md_rad(a), 1'b0);
      return neg ? -v : v;
    endfunction

    function longint cos_angle(bit [63:0] t);
      if (t > PI_QF / 2) return -series(PI_QF - t, 1'b0);
      return series(t, 1'b0);
    endfunction

    // largest angle whose cosine is still >= c, MSB-first search
    function bit [63:0] arc_cos(longint c);
      bit [63:0] lo, cand;
      int        b;
      lo = 0;
      if (c >= ONE_Q) return 0;
      if (c <= -ONE_Q) return PI_QF;
      for (b = FRAC + 1; b >= 0; b--) begin
        cand = lo | (64'd1 << b);
        if (cand <= PI_QF && cos_angle(cand) >= c) lo = cand;
      end
      return lo;
    endfunction

    function bit [14:0] predict(longint la, longint loa, longint lb, longint lob);
      longint     c;
      bit [63:0]  ang, scale;
      bit [127:0] d;
      if (la == lb && loa == lob) return '0;
      c = smul(sin_of(la), sin_of(lb)) +
          smul(smul(cos_of(la), cos_of(lb)), cos_of(loa - lob));
      if (c > ONE_Q) c = ONE_Q;
      if (c < -ONE_Q) c = -ONE_Q;
      ang = arc_cos(c);
      case (unit)
        UNIT_MILES: scale = MILES_Q16;
        UNIT_NM:    scale = NM_Q16;
        default:    scale = KM_Q16;
      endcase
      d = (128'(ang) * 128'(scale)) >> (FRAC + 16);
      if (d > 32767) d = 32767;
      return d[14:0];
    endfunction

    function void note_point(longint la, longint loa, longint lb, longint lob);
      expected_dist.insert(expected_dist.size(), predict(la, loa, lb, lob));
    endfunction

    function void check_distance(bit [14:0] got);
      bit [14:0] want;
      if (expected_dist.size() == 0) begin
        $error("distance: unexpected item, actual %0d", got);
        errors++;
        return;
      end
      want = expected_dist.pop_front();
      if (got !== want) begin
        $error("distance: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_wdata;
  logic               point_valid;
  logic               point_ready;
  logic signed [17:0] lat_a;
  logic signed [18:0] lon_a;
  logic signed [17:0] lat_b;
  logic signed [18:0] lon_b;
  logic               dist_valid;
  logic               dist_ready;
  logic [14:0]        distance;

  distance_checker sb = new();
  int  cycles = 0;
  bit  send_burst = 0;       // no input gaps while set
  bit  hold_request = 0;     // receiver does one long hold-off when set

  great_circle_distance dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .point_valid (point_valid),
    .point_ready (point_ready),
    .lat_a       (lat_a),
    .lon_a       (lon_a),
    .lat_b       (lat_b),
    .lon_b       (lon_b),
    .dist_valid  (dist_valid),
    .dist_ready  (dist_ready),
    .distance    (distance)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // handshake monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (point_valid && point_ready)
        sb.note_point(lat_a, lon_a, lat_b, lon_b);
      if (dist_valid && dist_ready)
        sb.check_distance(distance);
    end
  end

  // receiver: random stalls, stall-free stretches, one long hold-off
  initial begin
    int n, taken;
    taken = 0;
    dist_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        n = LONG_HOLD;
      end else if ((taken / 100) % 3 == 1) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 4);
      end
      if (n > 0) begin
        dist_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      dist_ready <= 1'b1;
      do @(posedge clk); while (!dist_valid);
      taken++;
    end
  end

  task automatic send_point(input int la, input int loa, input int lb, input int lob);
    int n;
    n = send_burst ? 0 : $urandom_range(0, 4);
    if (n > 0) begin
      point_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    lat_a <= 18'(la);
    lon_a <= 19'(loa);
    lat_b <= 18'(lb);
    lon_b <= 19'(lob);
    point_valid <= 1'b1;
    do @(posedge clk); while (!point_ready);
  endtask

  task automatic wait_drained();
    while (sb.expected_dist.size() != 0) @(posedge clk);
  endtask

  // the extra edge lets the monitor record the last accepted item first
  task automatic set_unit(input logic [1:0] u);
    point_valid <= 1'b0;
    @(posedge clk);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= u;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.unit = u;
  endtask

  // random pair: mostly real coordinates, some close pairs, some raw patterns
  task automatic send_random();
    int sel, la, loa, lb, lob;
    sel = $urandom_range(0, 99);
    la  = $urandom_range(0, 180000) - 90000;
    loa = $urandom_range(0, 360000) - 180000;
    if (sel < 80) begin
      lb  = $urandom_range(0, 180000) - 90000;
      lob = $urandom_range(0, 360000) - 180000;
    end else if (sel < 92) begin
      lb  = la + $urandom_range(0, 20) - 10;
      lob = loa + $urandom_range(0, 20) - 10;
    end else begin
      la  = $signed(18'($urandom));
      loa = $signed(19'($urandom));
      lb  = $signed(18'($urandom));
      lob = $signed(19'($urandom));
    end
    send_point(la, loa, lb, lob);
  endtask

  // main sequence
  initial begin
    logic [1:0] units[4];
    int p, i, done;
    units = '{UNIT_MILES, UNIT_NM, UNIT_SPARE, UNIT_KM};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = UNIT_KM;
    point_valid = 1'b0;
    lat_a = '0;
    lon_a = '0;
    lat_b = '0;
    lon_b = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pairs under the reset unit
    send_point(0, 0, 0, 0);
    send_point(131071, 262143, 131071, 262143);
    send_point(90000, 0, -90000, 0);
    send_point(0, 0, 0, 180000);
    send_point(0, -180000, 0, 180000);
    send_point(0, 0, 0, 1);
    send_point(0, 0, 1, 0);
    send_point(90000, 180000, 90000, -180000);
    send_point(-90000, 0, -90000, 123456);
    send_point(131071, 262143, -131072, -262144);
    send_point(-131072, -262144, 131071, 262143);
    send_point(-131072, 0, 0, -262144);
    send_point(45000, 90000, -45000, -90000);
    send_point(30000, 0, 30000, 90000);
    send_point(51500, -100, 48850, 2350);
    send_point(-33870, 151210, 40710, -74010);
    send_point(1, 1, -1, -1);
    send_point(89999, 179999, -89999, -179999);
    send_point(0, 0, 0, 179999);

    // random phases, one per unit, long output hold-off in the second
    for (p = 0; p < 5; p++) begin
      if (p == 1) hold_request = 1;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        send_burst = ((i / 60) % 3 == 2);
        send_random();
      end
      if (p < 4) set_unit(units[p]);
    end
    point_valid <= 1'b0;
    @(posedge clk);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    done = sb.errors + sb.expected_dist.size();
    if (done == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/gcdist_pkg.sv
rtl/core/gcdist_trig.sv
rtl/core/gcdist_acos.sv
rtl/core/great_circle_distance.sv
verif/great_circle_distance_tb.sv
